### design/ptfa_pkg.sv
// Shared constants, operation codes and status types for the paged translation block.
`default_nettype none

package ptfa_pkg;

    localparam int NUM_PROCS_DEF        = 16;
    localparam int PAGES_PER_PROC_DEF   = 1024;
    localparam int FRAME_COUNT_DEF      = 4096;
    localparam int PAGE_OFFSET_BITS_DEF = 12;

    localparam int VA_W     = 22;
    localparam int CMD_W    = 3;
    localparam int PIDIN_W  = 4;
    localparam int CNT_W    = 11;
    localparam int FLAGS_W  = 3;
    localparam int STATUS_W = 2;
    localparam int PHYS_OUT_W = 24;
    localparam int NEWID_W  = 4;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 32;

    localparam logic [CMD_W-1:0] CMD_READ   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_MAP    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_UNMAP  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_FREE   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_NEWPID = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SEGV    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOFRAME = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOPID   = 2'd3;

    localparam int PTE_READ_BIT    = 0;
    localparam int PTE_WRITE_BIT   = 1;
    localparam int PTE_PRESENT_BIT = 3;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LOAD,
        OP_MOD_STEP,
        OP_PT_READ,
        OP_XL_OK,
        OP_FAULT,
        OP_FR_READ,
        OP_FR_NEXT,
        OP_NOFRAME,
        OP_MAP_WRITE,
        OP_UNMAP_WRITE,
        OP_TD_INIT,
        OP_TD_WRITE,
        OP_TD_END,
        OP_PID_ALLOC,
        OP_RESULT
    } op_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             clr_last;
        logic             mod_last;
        logic             run_end;
        logic             td_end;
        logic             present;
        logic             xl_ok;
        logic             srch_end;
        logic             fr_free;
        logic             out_free;
    } stat_t;

endpackage

`default_nettype wire

### design/ptfa_datapath.sv
// Datapath: page table and frame map memories, run counters, allocators and result register.
`default_nettype none

module ptfa_datapath #(
    parameter int NUM_PROCS        = ptfa_pkg::NUM_PROCS_DEF,
    parameter int PAGES_PER_PROC   = ptfa_pkg::PAGES_PER_PROC_DEF,
    parameter int FRAME_COUNT      = ptfa_pkg::FRAME_COUNT_DEF,
    parameter int PAGE_OFFSET_BITS = ptfa_pkg::PAGE_OFFSET_BITS_DEF
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  ptfa_pkg::op_t                     op,
    input  wire [ptfa_pkg::IN_DATA_W-1:0]     in_data,
    output logic [ptfa_pkg::OUT_DATA_W-1:0]   out_data,
    output logic                              out_valid,
    input  wire                               out_ready,
    output ptfa_pkg::stat_t                   stat
);

    localparam int PID_W     = $clog2(NUM_PROCS);
    localparam int PG_W      = $clog2(PAGES_PER_PROC);
    localparam int PGC_W     = $clog2(PAGES_PER_PROC + 1);
    localparam int FR_W      = $clog2(FRAME_COUNT);
    localparam int FRC_W     = $clog2(FRAME_COUNT + 1);
    localparam int PT_DEPTH  = NUM_PROCS * PAGES_PER_PROC;
    localparam int PT_AW     = $clog2(PT_DEPTH);
    localparam int PTE_W     = FR_W + 4;
    localparam int VPN_W     = ptfa_pkg::VA_W - PAGE_OFFSET_BITS;
    localparam int MOD_STEPS = (VPN_W >= PG_W) ? (VPN_W - PG_W + 1) : 1;
    localparam int MW        = ((VPN_W > PG_W) ? VPN_W : PG_W) + 2;
    localparam int MK_W      = $clog2(MOD_STEPS + 1);
    localparam int CLR_N     = (PT_DEPTH > FRAME_COUNT) ? PT_DEPTH : FRAME_COUNT;
    localparam int CLR_W     = $clog2(CLR_N);
    localparam int PHYS_W    = FR_W + PAGE_OFFSET_BITS;

    logic [ptfa_pkg::CMD_W-1:0]    in_cmd;
    logic [ptfa_pkg::PIDIN_W-1:0]  in_pid;
    logic [ptfa_pkg::VA_W-1:0]     in_va;
    logic [ptfa_pkg::CNT_W-1:0]    in_cnt;
    logic [ptfa_pkg::FLAGS_W-1:0]  in_flags;

    assign in_cmd   = in_data[2:0];
    assign in_pid   = in_data[6:3];
    assign in_va    = in_data[28:7];
    assign in_cnt   = in_data[39:29];
    assign in_flags = in_data[42:40];

    logic [ptfa_pkg::CMD_W-1:0]    cmd_reg;
    logic [PID_W-1:0]              pid_reg;
    logic [PAGE_OFFSET_BITS-1:0]   off_reg;
    logic [MW-1:0]                 rem_reg;
    logic [MK_W-1:0]               mk_reg;
    logic [PGC_W-1:0]              page_reg;
    logic [ptfa_pkg::CNT_W-1:0]    cnt_reg;
    logic [ptfa_pkg::FLAGS_W-1:0]  flags_reg;
    logic [FRC_W-1:0]              srch_reg;
    logic [FRC_W-1:0]              hint_reg;
    logic [CLR_W-1:0]              clr_reg;
    logic [NUM_PROCS-1:0]          proc_used_reg;
    logic [ptfa_pkg::STATUS_W-1:0] res_status_reg;
    logic [ptfa_pkg::PHYS_OUT_W-1:0] res_phys_reg;
    logic [ptfa_pkg::NEWID_W-1:0]  res_newid_reg;
    logic                          res_killed_reg;
    logic [ptfa_pkg::OUT_DATA_W-1:0] out_data_reg;
    logic                          out_valid_reg;
    logic [PTE_W-1:0]              pt_q_reg;
    logic                          fr_q_reg;

    logic [PTE_W-1:0] pt_mem [PT_DEPTH];
    logic             fr_mem [FRAME_COUNT];

    // Process id reduced modulo the number of processes.
    logic [11:0]      pid_rem;
    logic [PID_W-1:0] pid_mod;
    always_comb
    begin
        pid_rem = 12'(in_pid);
        for (int k = 3; k >= 0; k--)
        begin
            if (pid_rem >= (12'(NUM_PROCS) << k))
            begin
                pid_rem = pid_rem - (12'(NUM_PROCS) << k);
            end
        end
        pid_mod = pid_rem[PID_W-1:0];
    end

    logic [MW-1:0] mod_sub;
    logic [MW-1:0] rem_next;
    assign mod_sub  = MW'(PAGES_PER_PROC) << mk_reg;
    assign rem_next = (rem_reg >= mod_sub) ? (rem_reg - mod_sub) : rem_reg;

    // Lowest free process id.
    logic             pid_found;
    logic [PID_W-1:0] pid_free;
    always_comb
    begin
        pid_found = 1'b0;
        pid_free  = '0;
        for (int i = NUM_PROCS - 1; i >= 0; i--)
        begin
            if (!proc_used_reg[i])
            begin
                pid_found = 1'b1;
                pid_free  = PID_W'(i);
            end
        end
    end

    logic [PT_AW-1:0] pt_addr;
    logic [FR_W-1:0]  pt_frame;
    logic             present;
    logic             need_ok;
    logic             run_end;
    logic             td_end;
    logic [PHYS_W+ptfa_pkg::PHYS_OUT_W-1:0] phys_wide;
    logic [PID_W+ptfa_pkg::NEWID_W-1:0]     newid_wide;

    assign pt_addr    = PT_AW'(pid_reg) * PT_AW'(PAGES_PER_PROC) + PT_AW'(page_reg[PG_W-1:0]);
    assign pt_frame   = pt_q_reg[PTE_W-1:4];
    assign present    = pt_q_reg[ptfa_pkg::PTE_PRESENT_BIT];
    assign need_ok    = (cmd_reg == ptfa_pkg::CMD_WRITE) ? pt_q_reg[ptfa_pkg::PTE_WRITE_BIT]
                                                         : pt_q_reg[ptfa_pkg::PTE_READ_BIT];
    assign td_end     = (page_reg == PGC_W'(PAGES_PER_PROC));
    assign run_end    = (cnt_reg == '0) || td_end;
    assign phys_wide  = {{ptfa_pkg::PHYS_OUT_W{1'b0}}, pt_frame, off_reg};
    assign newid_wide = {{ptfa_pkg::NEWID_W{1'b0}}, pid_free};

    logic             clr_pt;
    logic             clr_fr;
    logic             pt_we;
    logic [PT_AW-1:0] pt_waddr;
    logic [PTE_W-1:0] pt_wdata;
    logic             fr_we;
    logic [FR_W-1:0]  fr_waddr;
    logic             fr_wdata;
    logic             release_fr;

    assign clr_pt = (32'(clr_reg) < PT_DEPTH);
    assign clr_fr = (32'(clr_reg) < FRAME_COUNT);

    always_comb
    begin
        pt_we      = 1'b0;
        pt_waddr   = pt_addr;
        pt_wdata   = '0;
        fr_we      = 1'b0;
        fr_waddr   = pt_frame;
        fr_wdata   = 1'b0;
        release_fr = 1'b0;
        case (op)
            ptfa_pkg::OP_CLEAR:
            begin
                pt_we    = clr_pt;
                pt_waddr = clr_reg[PT_AW-1:0];
                fr_we    = clr_fr;
                fr_waddr = clr_reg[FR_W-1:0];
            end
            ptfa_pkg::OP_MAP_WRITE:
            begin
                pt_we    = 1'b1;
                pt_wdata = {srch_reg[FR_W-1:0], 1'b1, flags_reg};
                fr_we    = 1'b1;
                fr_waddr = srch_reg[FR_W-1:0];
                fr_wdata = 1'b1;
            end
            ptfa_pkg::OP_UNMAP_WRITE:
            begin
                pt_we      = 1'b1;
                fr_we      = 1'b1;
                release_fr = 1'b1;
            end
            ptfa_pkg::OP_TD_WRITE:
            begin
                pt_we      = 1'b1;
                fr_we      = present;
                release_fr = present;
            end
            default:
            begin
                pt_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pt_we)
        begin
            pt_mem[pt_waddr] <= pt_wdata;
        end
        if (op == ptfa_pkg::OP_PT_READ)
        begin
            pt_q_reg <= pt_mem[pt_addr];
        end
        if (fr_we)
        begin
            fr_mem[fr_waddr] <= fr_wdata;
        end
        if (op == ptfa_pkg::OP_FR_READ)
        begin
            fr_q_reg <= fr_mem[srch_reg[FR_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        case (op)
            ptfa_pkg::OP_LOAD:
            begin
                cmd_reg        <= in_cmd;
                pid_reg        <= pid_mod;
                off_reg        <= in_va[PAGE_OFFSET_BITS-1:0];
                rem_reg        <= MW'(in_va[ptfa_pkg::VA_W-1:PAGE_OFFSET_BITS]);
                mk_reg         <= MK_W'(MOD_STEPS - 1);
                cnt_reg        <= in_cnt;
                flags_reg      <= in_flags;
                res_status_reg <= ptfa_pkg::ST_OK;
                res_phys_reg   <= '0;
                res_newid_reg  <= '0;
                res_killed_reg <= 1'b0;
            end
            ptfa_pkg::OP_MOD_STEP:
            begin
                rem_reg  <= rem_next;
                mk_reg   <= mk_reg - 1'b1;
                page_reg <= PGC_W'(rem_next);
            end
            ptfa_pkg::OP_PT_READ:
            begin
                srch_reg <= hint_reg;
            end
            ptfa_pkg::OP_XL_OK:
            begin
                res_phys_reg <= phys_wide[ptfa_pkg::PHYS_OUT_W-1:0];
            end
            ptfa_pkg::OP_FAULT:
            begin
                res_status_reg <= ptfa_pkg::ST_SEGV;
                res_killed_reg <= 1'b1;
                page_reg       <= '0;
            end
            ptfa_pkg::OP_FR_NEXT:
            begin
                srch_reg <= srch_reg + 1'b1;
            end
            ptfa_pkg::OP_NOFRAME:
            begin
                res_status_reg <= ptfa_pkg::ST_NOFRAME;
            end
            ptfa_pkg::OP_MAP_WRITE, ptfa_pkg::OP_UNMAP_WRITE:
            begin
                page_reg <= page_reg + 1'b1;
                cnt_reg  <= cnt_reg - 1'b1;
            end
            ptfa_pkg::OP_TD_INIT:
            begin
                page_reg <= '0;
            end
            ptfa_pkg::OP_TD_WRITE:
            begin
                page_reg <= page_reg + 1'b1;
            end
            ptfa_pkg::OP_PID_ALLOC:
            begin
                if (pid_found)
                begin
                    res_newid_reg <= newid_wide[ptfa_pkg::NEWID_W-1:0];
                end
                else
                begin
                    res_status_reg <= ptfa_pkg::ST_NOPID;
                end
            end
            ptfa_pkg::OP_RESULT:
            begin
                out_data_reg <= {1'b0, res_killed_reg, res_newid_reg, res_phys_reg,
                                 res_status_reg};
            end
            default:
            begin
                cmd_reg <= cmd_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg       <= '0;
            hint_reg      <= '0;
            proc_used_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (op == ptfa_pkg::OP_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (op == ptfa_pkg::OP_MAP_WRITE)
            begin
                hint_reg <= srch_reg + 1'b1;
            end
            else if (release_fr && (FRC_W'(pt_frame) < hint_reg))
            begin
                hint_reg <= FRC_W'(pt_frame);
            end
            if (op == ptfa_pkg::OP_TD_END)
            begin
                proc_used_reg[pid_reg] <= 1'b0;
            end
            else if ((op == ptfa_pkg::OP_PID_ALLOC) && pid_found)
            begin
                proc_used_reg[pid_free] <= 1'b1;
            end
            if (op == ptfa_pkg::OP_RESULT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_data  = out_data_reg;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        stat.cmd      = cmd_reg;
        stat.clr_last = (clr_reg == CLR_W'(CLR_N - 1));
        stat.mod_last = (mk_reg == '0);
        stat.run_end  = run_end;
        stat.td_end   = td_end;
        stat.present  = present;
        stat.xl_ok    = present && need_ok;
        stat.srch_end = (srch_reg == FRC_W'(FRAME_COUNT));
        stat.fr_free  = !fr_q_reg;
        stat.out_free = !out_valid_reg || out_ready;
    end

    a_hint_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(hint_reg) <= FRAME_COUNT)
        else $error("frame hint beyond frame count");

    a_alloc_free: assert property (@(posedge clk) disable iff (!rst_n)
        (op == ptfa_pkg::OP_MAP_WRITE) |-> (!fr_q_reg && !stat.srch_end))
        else $error("frame handed out that is in use");

    a_result_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (op == ptfa_pkg::OP_RESULT) |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten");

endmodule

`default_nettype wire

### design/ptfa_ctrl.sv
// Controller state machine sequencing clearing, translation, map, unmap, teardown and id allocation.
`default_nettype none

module ptfa_ctrl (
    input  wire             clk,
    input  wire             rst_n,
    input  wire             in_valid,
    output logic            in_ready,
    input  ptfa_pkg::stat_t stat,
    output ptfa_pkg::op_t   op
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_DISPATCH,
        S_XLATE,
        S_MAP_TEST,
        S_MAP_CHK,
        S_FR_SCAN,
        S_FR_CHK,
        S_UNMAP_TEST,
        S_UNMAP_CHK,
        S_TD_RD,
        S_TD_WR,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        op         = ptfa_pkg::OP_NONE;
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                op = ptfa_pkg::OP_CLEAR;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op         = ptfa_pkg::OP_LOAD;
                    state_next = S_MOD;
                end
            end
            S_MOD:
            begin
                op = ptfa_pkg::OP_MOD_STEP;
                if (stat.mod_last)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (stat.cmd)
                    ptfa_pkg::CMD_READ, ptfa_pkg::CMD_WRITE:
                    begin
                        op         = ptfa_pkg::OP_PT_READ;
                        state_next = S_XLATE;
                    end
                    ptfa_pkg::CMD_MAP:    state_next = S_MAP_TEST;
                    ptfa_pkg::CMD_UNMAP:  state_next = S_UNMAP_TEST;
                    ptfa_pkg::CMD_FREE:
                    begin
                        op         = ptfa_pkg::OP_TD_INIT;
                        state_next = S_TD_RD;
                    end
                    ptfa_pkg::CMD_NEWPID:
                    begin
                        op         = ptfa_pkg::OP_PID_ALLOC;
                        state_next = S_FINISH;
                    end
                    default:              state_next = S_FINISH;
                endcase
            end
            S_XLATE:
            begin
                if (stat.xl_ok)
                begin
                    op         = ptfa_pkg::OP_XL_OK;
                    state_next = S_FINISH;
                end
                else
                begin
                    op         = ptfa_pkg::OP_FAULT;
                    state_next = S_TD_RD;
                end
            end
            S_MAP_TEST:
            begin
                if (stat.run_end)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    op         = ptfa_pkg::OP_PT_READ;
                    state_next = S_MAP_CHK;
                end
            end
            S_MAP_CHK:
            begin
                if (stat.present)
                begin
                    op         = ptfa_pkg::OP_FAULT;
                    state_next = S_TD_RD;
                end
                else
                begin
                    state_next = S_FR_SCAN;
                end
            end
            S_FR_SCAN:
            begin
                if (stat.srch_end)
                begin
                    op         = ptfa_pkg::OP_NOFRAME;
                    state_next = S_FINISH;
                end
                else
                begin
                    op         = ptfa_pkg::OP_FR_READ;
                    state_next = S_FR_CHK;
                end
            end
            S_FR_CHK:
            begin
                if (stat.fr_free)
                begin
                    op         = ptfa_pkg::OP_MAP_WRITE;
                    state_next = S_MAP_TEST;
                end
                else
                begin
                    op         = ptfa_pkg::OP_FR_NEXT;
                    state_next = S_FR_SCAN;
                end
            end
            S_UNMAP_TEST:
            begin
                if (stat.run_end)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    op         = ptfa_pkg::OP_PT_READ;
                    state_next = S_UNMAP_CHK;
                end
            end
            S_UNMAP_CHK:
            begin
                if (stat.present)
                begin
                    op         = ptfa_pkg::OP_UNMAP_WRITE;
                    state_next = S_UNMAP_TEST;
                end
                else
                begin
                    op         = ptfa_pkg::OP_FAULT;
                    state_next = S_TD_RD;
                end
            end
            S_TD_RD:
            begin
                if (stat.td_end)
                begin
                    op         = ptfa_pkg::OP_TD_END;
                    state_next = S_FINISH;
                end
                else
                begin
                    op         = ptfa_pkg::OP_PT_READ;
                    state_next = S_TD_WR;
                end
            end
            S_TD_WR:
            begin
                op         = ptfa_pkg::OP_TD_WRITE;
                state_next = S_TD_RD;
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    op         = ptfa_pkg::OP_RESULT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

endmodule

`default_nettype wire

### design/paged_translation_with_frame_allocator.sv
// Top level of the paged translation block with lowest-free frame and process id allocation.
// One item is worked on at a time; a read or write check loads the item, reduces its page
// number modulo the pages per process, reads and checks the page table entry, and shows its
// result once the output register is free. Map reads and checks each page, then scans the
// frame map for a free frame; unmap reads and clears each page. A teardown walks the whole
// table of the process. After reset a pass clears the page table and frame map first.
`default_nettype none

module paged_translation_with_frame_allocator #(
    parameter int NUM_PROCS        = ptfa_pkg::NUM_PROCS_DEF,
    parameter int PAGES_PER_PROC   = ptfa_pkg::PAGES_PER_PROC_DEF,
    parameter int FRAME_COUNT      = ptfa_pkg::FRAME_COUNT_DEF,
    parameter int PAGE_OFFSET_BITS = ptfa_pkg::PAGE_OFFSET_BITS_DEF
) (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             s_tvalid,
    output logic                            s_tready,
    // cmd[2:0], proc_id[6:3], virt_addr[28:7], page_count[39:29], perm_flags[42:40]
    input  wire [ptfa_pkg::IN_DATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  wire                             m_tready,
    // status[1:0], phys_addr[25:2], new_proc_id[29:26], proc_killed[30]
    output logic [ptfa_pkg::OUT_DATA_W-1:0] m_tdata
);

    ptfa_pkg::op_t   op;
    ptfa_pkg::stat_t stat;

    ptfa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .op       (op)
    );

    ptfa_datapath #(
        .NUM_PROCS        (NUM_PROCS),
        .PAGES_PER_PROC   (PAGES_PER_PROC),
        .FRAME_COUNT      (FRAME_COUNT),
        .PAGE_OFFSET_BITS (PAGE_OFFSET_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .in_data   (s_tdata),
        .out_data  (m_tdata),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .stat      (stat)
    );

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second item taken while one is in work");

    a_load_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (op == ptfa_pkg::OP_LOAD) |-> (s_tvalid && s_tready))
        else $error("item latched without a handshake");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (op == ptfa_pkg::OP_RESULT) |=> (m_tvalid && s_tready))
        else $error("result not presented on completion");

endmodule

`default_nettype wire
